@@ rtl/core/binary_patch_applier_macros.svh @@
// ----------------------------------------------------------------------------
// Binary patch applier assertion macros
// Shared concurrent assertion shorthands for the patch applier checkers.
// ----------------------------------------------------------------------------
`ifndef BINARY_PATCH_APPLIER_MACROS_SVH
`define BINARY_PATCH_APPLIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Binary patch applier package
// Shared types and codes for the front queue and the patch executor.
// ----------------------------------------------------------------------------
package bpa_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DIFF   = 2'd1,
    PH_EXTRA  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_DONE   = 2'd1,
    ST_BADLEN = 2'd2,
    ST_TRUNC  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  // Configuration register indexes
  localparam logic CFG_OLD_SIZE = 1'b0;
  localparam logic CFG_NEW_SIZE = 1'b1;

  localparam int unsigned SizeW = 24;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] patch_byte;
    logic [7:0] old_byte;
  } item_t;

endpackage

@@ rtl/core/binary_patch_applier.sv @@
// ----------------------------------------------------------------------------
// Binary patch applier
// Streaming applier for uncompressed bsdiff-style patches, one byte per beat.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the result side is not stalled.
// An accepted beat passes the front queue, then the result register.
// The front queue holds two beats, so up to two input beats are still
// accepted while the result side is stalled.
// Reset: all patch state and both size registers clear; with a zero new
// image size the first beat reports done.
module binary_patch_applier #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port: index 0 old image size, 1 new image size
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  // Patch input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] patch_byte, [15:8] old_byte
  input  logic [0:0]  s_axis_tuser,  // [0] action
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [23:0] write_offset, [31:24] write_data,
                                     // [63:32] next_old_offset
  output logic [2:0]  m_axis_tuser   // [0] write_valid, [2:1] status
);

  logic           item_valid;
  logic           item_pop;
  bpa_pkg::item_t item;

  // Front: accept and tag beats, queue them for the executor
  bpa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  // Back: run the record state machine, drive the result register
  bpa_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ rtl/core/bpa_front.sv @@
// ----------------------------------------------------------------------------
// Patch applier front end
// Accept input beats, tag them as patch bytes or end markers, and hold them
// in a two-entry queue until the executor takes them.
// ----------------------------------------------------------------------------
module bpa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,  // [7:0] patch_byte, [15:8] old_byte
  input  logic [0:0]    s_axis_tuser,  // [0] action
  output logic          item_valid_o,
  output bpa_pkg::item_t item_o,
  input  logic          item_pop_i
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bpa_pkg::item_t   mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;
  bpa_pkg::item_t   in_item;

  always_comb begin
    in_item.kind       = s_axis_tuser[0] ? bpa_pkg::KIND_END : bpa_pkg::KIND_BYTE;
    in_item.patch_byte = s_axis_tdata[7:0];
    in_item.old_byte   = s_axis_tdata[15:8];
  end

  assign s_axis_tready = (count_q != CntW'(Depth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (count_q != '0);
  assign pop           = item_pop_i && item_valid_o;
  assign item_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/core/bpa_back.sv @@
// ----------------------------------------------------------------------------
// Patch applier executor
// Decode record headers, apply diff and extra sections, track status, and
// drive the registered result beat.
// ----------------------------------------------------------------------------
module bpa_back #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [23:0]          cfg_wdata_i,
  input  logic                 item_valid_i,
  input  bpa_pkg::item_t       item_i,
  output logic                 item_pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,  // [23:0] write_offset, [31:24] write_data,
                                              // [63:32] next_old_offset
  output logic [2:0]           m_axis_tuser   // [0] write_valid, [2:1] status
);

  localparam int unsigned SizeW = bpa_pkg::SizeW;
  localparam logic [SizeW-1:0] NewSizeMask =
    SizeW'((64'd1 << ADDR_BITS) - 64'd1);

  // Configuration
  logic [SizeW-1:0] old_size_q, new_size_q;

  // Patch state
  bpa_pkg::phase_e  phase_q, phase_d;
  bpa_pkg::status_e status_q, status_d;
  logic [1:0]       hfield_q, hfield_d;
  logic [2:0]       hcount_q, hcount_d;
  logic [31:0]      acc_q, acc_d;
  logic [31:0]      diff_len_q, diff_len_d;
  logic [31:0]      extra_len_q, extra_len_d;
  logic [31:0]      seek_q, seek_d;
  logic [31:0]      remain_q, remain_d;
  logic [31:0]      old_pos_q, old_pos_d;
  logic [ADDR_BITS-1:0] new_pos_q, new_pos_d;

  // Result register
  logic             out_valid_q;
  logic             wvalid_q, wvalid_d;
  logic [SizeW-1:0] woff_q, woff_d;
  logic [7:0]       wdata_q, wdata_d;

  logic             advance;
  logic [31:0]      hdr_val;
  logic [32:0]      new_size_ext;

  assign advance      = item_valid_i && (!out_valid_q || m_axis_tready);
  assign item_pop_o   = advance;
  assign new_size_ext = 33'(new_size_q);
  assign hdr_val      = item_i.patch_byte[7] ? (32'd0 - acc_q) : acc_q;

  always_comb begin
    phase_d     = phase_q;
    status_d    = status_q;
    hfield_d    = hfield_q;
    hcount_d    = hcount_q;
    acc_d       = acc_q;
    diff_len_d  = diff_len_q;
    extra_len_d = extra_len_q;
    seek_d      = seek_q;
    remain_d    = remain_q;
    old_pos_d   = old_pos_q;
    new_pos_d   = new_pos_q;
    wvalid_d    = 1'b0;
    woff_d      = '0;
    wdata_d     = '0;

    // Record boundary before the beat
    if (status_d == bpa_pkg::ST_RUN && phase_q == bpa_pkg::PH_HEADER &&
        hfield_q == 2'd0 && hcount_q == 3'd0 &&
        33'(new_pos_q) >= new_size_ext) begin
      status_d = bpa_pkg::ST_DONE;
    end

    if (status_d == bpa_pkg::ST_RUN) begin
      if (item_i.kind == bpa_pkg::KIND_END) begin
        status_d = bpa_pkg::ST_TRUNC;
      end else begin
        unique case (phase_q)
          bpa_pkg::PH_DIFF: begin
            if (!old_pos_q[31] && 32'(old_pos_q[30:0]) < 32'(old_size_q)) begin
              wvalid_d = 1'b1;
              woff_d   = SizeW'(new_pos_q);
              wdata_d  = item_i.patch_byte + item_i.old_byte;
            end
            new_pos_d = new_pos_q + ADDR_BITS'(1);
            old_pos_d = old_pos_q + 32'd1;
            remain_d  = remain_q - 32'd1;
            if (remain_q == 32'd1) begin
              if (33'(new_pos_d) + 33'(extra_len_q) > new_size_ext) begin
                status_d = bpa_pkg::ST_BADLEN;
              end else if (extra_len_q != 32'd0) begin
                remain_d = extra_len_q;
                phase_d  = bpa_pkg::PH_EXTRA;
              end else begin
                old_pos_d = old_pos_q + seek_q + 32'd1;
                phase_d   = bpa_pkg::PH_HEADER;
              end
            end
          end
          bpa_pkg::PH_EXTRA: begin
            wvalid_d  = 1'b1;
            woff_d    = SizeW'(new_pos_q);
            wdata_d   = item_i.patch_byte;
            new_pos_d = new_pos_q + ADDR_BITS'(1);
            remain_d  = remain_q - 32'd1;
            if (remain_q == 32'd1) begin
              old_pos_d = old_pos_q + seek_q;
              phase_d   = bpa_pkg::PH_HEADER;
            end
          end
          bpa_pkg::PH_HEADER: begin
            if (hcount_q < 3'd4) begin
              acc_d[8*hcount_q[1:0] +: 8] = acc_q[8*hcount_q[1:0] +: 8] |
                                            item_i.patch_byte;
              hcount_d = hcount_q + 3'd1;
            end else if (hcount_q < 3'd7) begin
              hcount_d = hcount_q + 3'd1;
            end else begin
              acc_d    = '0;
              hcount_d = '0;
              priority case (hfield_q)
                2'd0: diff_len_d  = hdr_val;
                2'd1: extra_len_d = hdr_val;
                default: seek_d   = hdr_val;
              endcase
              if (hfield_q >= 2'd2) begin
                hfield_d = 2'd0;
                // Header complete: check lengths and pick the first section; with both sections empty, apply the seek
                if (diff_len_q[31] || extra_len_q[31] ||
                    33'(new_pos_q) + 33'(diff_len_q) > new_size_ext) begin
                  status_d = bpa_pkg::ST_BADLEN;
                end else if (diff_len_q != 32'd0) begin
                  remain_d = diff_len_q;
                  phase_d  = bpa_pkg::PH_DIFF;
                end else if (33'(new_pos_q) + 33'(extra_len_q) > new_size_ext) begin
                  status_d = bpa_pkg::ST_BADLEN;
                end else if (extra_len_q != 32'd0) begin
                  remain_d = extra_len_q;
                  phase_d  = bpa_pkg::PH_EXTRA;
                end else begin
                  old_pos_d = item_i.patch_byte[7] ? (old_pos_q - acc_q)
                                                   : (old_pos_q + acc_q);
                end
              end else begin
                hfield_d = hfield_q + 2'd1;
              end
            end
          end
          default: ;
        endcase
      end

      // Record boundary after the beat
      if (status_d == bpa_pkg::ST_RUN && phase_d == bpa_pkg::PH_HEADER &&
          hfield_d == 2'd0 && hcount_d == 3'd0 &&
          33'(new_pos_d) >= new_size_ext) begin
        status_d = bpa_pkg::ST_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_size_q <= '0;
      new_size_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpa_pkg::CFG_OLD_SIZE: old_size_q <= cfg_wdata_i;
        bpa_pkg::CFG_NEW_SIZE: new_size_q <= cfg_wdata_i & NewSizeMask;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bpa_pkg::PH_HEADER;
      status_q    <= bpa_pkg::ST_RUN;
      hfield_q    <= '0;
      hcount_q    <= '0;
      acc_q       <= '0;
      diff_len_q  <= '0;
      extra_len_q <= '0;
      seek_q      <= '0;
      remain_q    <= '0;
      old_pos_q   <= '0;
      new_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q     <= phase_d;
        status_q    <= status_d;
        hfield_q    <= hfield_d;
        hcount_q    <= hcount_d;
        acc_q       <= acc_d;
        diff_len_q  <= diff_len_d;
        extra_len_q <= extra_len_d;
        seek_q      <= seek_d;
        remain_q    <= remain_d;
        old_pos_q   <= old_pos_d;
        new_pos_q   <= new_pos_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; status and old offset come from the state registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      wvalid_q <= wvalid_d;
      woff_q   <= woff_d;
      wdata_q  <= wdata_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {old_pos_q, wdata_q, woff_q};
  assign m_axis_tuser  = {status_q, wvalid_q};

endmodule

@@ rtl/core/bpa_checker.sv @@
// ----------------------------------------------------------------------------
// Patch applier port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_patch_applier_macros.svh"

module bpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A beat without a write carries zero offset and data
  `BPA_ASSERT_NOW(a_nowrite_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0, "result without write has nonzero offset or data")

  // A truncation result never writes
  `BPA_ASSERT_NOW(a_trunc_nowrite, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2:1] == bpa_pkg::ST_TRUNC, !m_axis_tuser[0], "truncation result carries a write")

  // A stalled result beat holds
  `BPA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

endmodule

bind binary_patch_applier bpa_checker u_bpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
